FILE: rtl/core/fpt_pkg.sv
// ============================================================================
// fpt_pkg - shared types and constants of the frame pacing timer
// Field widths, pacing constants and the command and status groups that
// pass between the controller and the datapath.
// ============================================================================
package fpt_pkg;

   localparam int TIME_W  = 32;
   localparam int FPS_W   = 10;
   localparam int COUNT_W = 16;
   localparam int RATE_W  = 24;

   // The rate numerator is frame_count * 1000 * 256, which needs 34 bits.
   localparam int NUM_W     = 34;
   localparam int DIV_CNT_W = 6;
   localparam int FRAC_W    = 8;

   localparam logic [TIME_W-1:0]    ONE_SECOND = 32'd1000;
   localparam logic [FPS_W-1:0]     FPS_RESET  = 10'd30;
   localparam logic [COUNT_W-1:0]   COUNT_MAX  = 16'hFFFF;
   localparam logic [RATE_W-1:0]    RATE_MAX   = 24'hFFFFFF;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 6'(NUM_W - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the new time sample
      logic mul;        // register the scaled time since the last frame
      logic eval;       // pacing decision and frame bookkeeping
      logic num_load;   // form the rate numerator and start the divider
      logic div_step;   // one quotient bit of the rate division
      logic commit;     // store the rate and restart the window
      logic rsp_load;   // move the finished result into the output register
   } fpt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic due;        // pacing sum reached one second
      logic win_done;   // measurement window has run for one second
      logic div_last;   // final division step is under way
   } fpt_sts_type;

endpackage

FILE: rtl/core/fpt_datapath.sv
// ============================================================================
// fpt_datapath - pacing arithmetic, state registers and rate divider
// Holds the timing state, forms the pacing sum, and runs a restoring
// divider one quotient bit per cycle for the measured rate.
// ============================================================================
module fpt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fpt_pkg::FPS_W-1:0]     csr_wdata,
   input  logic [fpt_pkg::TIME_W-1:0]    now_ms,
   input  fpt_pkg::fpt_cmd_type          cmd,
   output fpt_pkg::fpt_sts_type          sts,
   output logic                          rsp_frame_due,
   output logic                          rsp_rate_updated,
   output logic [fpt_pkg::RATE_W-1:0]    rsp_measured_rate
);

   logic [fpt_pkg::FPS_W-1:0]     fps_ff;
   logic [fpt_pkg::TIME_W-1:0]    now_ff;
   logic [fpt_pkg::TIME_W-1:0]    prod_ff, prod_in;
   logic [fpt_pkg::TIME_W-1:0]    last_frame_ff;
   logic [fpt_pkg::TIME_W-1:0]    carried_err_ff, carried_err_in;
   logic [fpt_pkg::TIME_W-1:0]    window_start_ff;
   logic [fpt_pkg::COUNT_W-1:0]   frame_count_ff, frame_count_in;
   logic [fpt_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic [fpt_pkg::TIME_W-1:0]    elapsed_ff;
   logic [fpt_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [fpt_pkg::NUM_W-1:0]     quot_ff, quot_in;
   logic [fpt_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                          due_ff, upd_ff;
   logic                          rsp_due_ff, rsp_upd_ff;
   logic [fpt_pkg::RATE_W-1:0]    rsp_rate_ff;

   logic [fpt_pkg::TIME_W-1:0]             since;
   logic [fpt_pkg::TIME_W+fpt_pkg::FPS_W-1:0] prod_full;
   logic [fpt_pkg::TIME_W-1:0]             diff, excess, elapsed;
   logic [fpt_pkg::NUM_W-fpt_pkg::FRAC_W-1:0] num_int;
   logic [fpt_pkg::TIME_W:0]               trial, trial_sub;

   // Pacing arithmetic, all modulo 2^32.
   always_comb begin
      since     = now_ff - last_frame_ff;
      prod_full = (fpt_pkg::TIME_W+fpt_pkg::FPS_W)'(since)
                  * (fpt_pkg::TIME_W+fpt_pkg::FPS_W)'(fps_ff);
      prod_in   = prod_full[fpt_pkg::TIME_W-1:0];
      diff      = prod_ff + carried_err_ff;
      excess    = diff - fpt_pkg::ONE_SECOND;
      elapsed   = now_ff - window_start_ff;
      carried_err_in = (excess < fpt_pkg::ONE_SECOND) ? excess : fpt_pkg::ONE_SECOND;
      frame_count_in = (frame_count_ff != fpt_pkg::COUNT_MAX) ?
                       frame_count_ff + 1'b1 : frame_count_ff;
   end

   assign sts.due      = (diff >= fpt_pkg::ONE_SECOND);
   assign sts.win_done = (elapsed >= fpt_pkg::ONE_SECOND);
   assign sts.div_last = (div_cnt_ff == '0);

   // Restoring division step: shift in the next numerator bit, subtract
   // the window length when it fits.
   always_comb begin
      num_int   = (fpt_pkg::NUM_W-fpt_pkg::FRAC_W)'(frame_count_ff)
                  * (fpt_pkg::NUM_W-fpt_pkg::FRAC_W)'(fpt_pkg::ONE_SECOND);
      trial     = {rem_ff, quot_ff[fpt_pkg::NUM_W-1]};
      trial_sub = trial - {1'b0, elapsed_ff};
      if (!trial_sub[fpt_pkg::TIME_W]) begin
         rem_in  = trial_sub[fpt_pkg::TIME_W-1:0];
         quot_in = {quot_ff[fpt_pkg::NUM_W-2:0], 1'b1};
      end else begin
         rem_in  = trial[fpt_pkg::TIME_W-1:0];
         quot_in = {quot_ff[fpt_pkg::NUM_W-2:0], 1'b0};
      end
      rate_in = (quot_ff[fpt_pkg::NUM_W-1:fpt_pkg::RATE_W] != '0) ?
                fpt_pkg::RATE_MAX : quot_ff[fpt_pkg::RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff          <= fpt_pkg::FPS_RESET;
         last_frame_ff   <= '0;
         carried_err_ff  <= '0;
         window_start_ff <= '0;
         frame_count_ff  <= '0;
         rate_ff         <= '0;
         div_cnt_ff      <= '0;
      end else begin
         if (csr_we) begin
            fps_ff <= csr_wdata;
         end
         if (cmd.eval && sts.due) begin
            carried_err_ff <= carried_err_in;
            last_frame_ff  <= now_ff;
            frame_count_ff <= frame_count_in;
         end
         if (cmd.num_load) begin
            div_cnt_ff <= fpt_pkg::DIV_LAST;
         end else if (cmd.div_step && !sts.div_last) begin
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         if (cmd.commit) begin
            rate_ff         <= rate_in;
            frame_count_ff  <= '0;
            window_start_ff <= now_ff;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff <= now_ms;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.eval) begin
         due_ff     <= sts.due;
         upd_ff     <= sts.due && sts.win_done;
         elapsed_ff <= elapsed;
      end
      if (cmd.num_load) begin
         quot_ff <= {num_int, {fpt_pkg::FRAC_W{1'b0}}};
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
      if (cmd.rsp_load) begin
         rsp_due_ff  <= due_ff;
         rsp_upd_ff  <= upd_ff;
         rsp_rate_ff <= rate_ff;
      end
   end

   assign rsp_frame_due     = rsp_due_ff;
   assign rsp_rate_updated  = rsp_upd_ff;
   assign rsp_measured_rate = rsp_rate_ff;

endmodule

FILE: rtl/core/fpt_ctrl.sv
// ============================================================================
// fpt_ctrl - sequencing state machine of the frame pacing timer
// Steps one sample through multiply, decision, optional rate division and
// hand-off to the output register.
// ============================================================================
module fpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  fpt_pkg::fpt_sts_type sts,
   output fpt_pkg::fpt_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_NUM,
      ST_DIV,
      ST_COMMIT,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = (sts.due && sts.win_done) ? ST_NUM : ST_SEND;
         end
         ST_NUM: begin
            cmd.num_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_MUL)
      else $error("accepted sample did not start the multiply step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a beat was still pending");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && sts.div_last |=> state_ff == ST_COMMIT)
      else $error("divider finished but the rate was not committed");

   a_no_frame_skips_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && !sts.due |=> state_ff == ST_SEND)
      else $error("sample without a frame entered the rate division");

endmodule

FILE: rtl/core/frame_pacing_timer_unit.sv
// ============================================================================
// frame_pacing_timer_unit - frame rate limiter with error accumulation
// Every millisecond time beat on the request stream yields one response
// beat telling whether a frame is due and carrying the measured rate.
// ============================================================================
// Usage:
//   The request stream carries one beat per time sample: req_tdata holds
//   now_ms. For each request beat exactly one response beat follows, in
//   order. rsp_tdata holds frame_due in bit 0 and measured_rate (unsigned
//   16.8 frames per second) in bits 24:1; rsp_tuser is high when that rate
//   was recomputed on this sample.
//   target_fps is written through csr_we / csr_wdata while no sample is in
//   flight; it resets to 30.
//   A sample that releases no rate update goes from acceptance through the
//   multiply and decision steps to a response beat. A sample that closes a
//   one-second measurement window also runs the rate division, which the
//   restoring divider resolves one quotient bit per cycle over 34 bits.
//   One sample is worked on at a time.
//   The finished response sits in an output register: a new request beat is
//   accepted while it waits, and only the hand-off of the next result
//   waits for rsp_tready.
//   Synchronous reset clears all timing state, the frame count and the
//   measured rate to zero and drops the response stream's valid state.
// ============================================================================
module frame_pacing_timer_unit (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] frame_due, [24:1] measured_rate, [31:25] zero
   output logic        rsp_tuser,   // [0] rate_updated
   // Configuration register.
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata    // [9:0] target_fps
);

   fpt_pkg::fpt_cmd_type             cmd;
   fpt_pkg::fpt_sts_type             sts;
   logic                             frame_due;
   logic [fpt_pkg::RATE_W-1:0]       measured_rate;

   // The controller sequences each sample and owns both handshakes.
   fpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the pacing state, the divider and the result.
   fpt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .now_ms            (req_tdata),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_frame_due     (frame_due),
      .rsp_rate_updated  (rsp_tuser),
      .rsp_measured_rate (measured_rate)
   );

   // Pack the response fields, lowest field first, zero padded to 32 bits.
   assign rsp_tdata = {7'b0, measured_rate, frame_due};

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking bench for the frame pacing timer
// Time samples are streamed into the unit while a cycle-free model of the
// pacing rule predicts every response beat: frame release, carried error,
// window close and the 16.8 rate division. Responses are compared field by
// field, in order. Both streams stall at random and the target rate is
// changed between phases.
// ============================================================================
module tb;

   localparam int LONG_HOLD   = 150;     // cycles the receiver holds off once
   localparam int TAIL_CYCLES = 60;      // longer than the rate division
   localparam int RANDOM_SAMPLES = 760;
   localparam int TAIL_SAMPLES = 40;
   localparam int REPORT_LIMIT = 40;

   typedef struct packed {
      logic        frame_due;
      logic        rate_updated;
      logic [23:0] measured_rate;
   } pace_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;       // [31:0] now_ms
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [0] frame_due, [24:1] measured_rate
   logic        rsp_tuser;            // [0] rate_updated
   logic        csr_we = 1'b0;
   logic [9:0]  csr_wdata = '0;       // [9:0] target_fps

   // Our own copy of the pacing state and of the target rate register.
   logic [fpt_pkg::FPS_W-1:0]   pace_fps        = fpt_pkg::FPS_RESET;
   logic [fpt_pkg::TIME_W-1:0]  pace_last_frame = '0;
   logic [fpt_pkg::TIME_W-1:0]  pace_error      = '0;
   logic [fpt_pkg::TIME_W-1:0]  pace_window     = '0;
   logic [fpt_pkg::COUNT_W-1:0] pace_count      = '0;
   logic [fpt_pkg::RATE_W-1:0]  pace_rate       = '0;

   logic [31:0]     pending_samples[$];
   pace_result_type expected_results[$];

   int   samples_issued = 0;
   int   samples_answered = 0;
   int   mismatches = 0;
   int   frames_seen = 0;
   int   updates_seen = 0;
   int   rate_settings = 0;
   int   send_gap = 0;
   int   take_gap = 0;
   bit   idle_on = 1'b0;
   logic rsp_hold = 1'b0;
   logic [31:0] sample_ms = '0;       // time of the most recently queued sample
   event long_hold_start;

   frame_pacing_timer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Pacing rule for one time sample. All time arithmetic wraps at 32 bits,
   // so backward steps and large jumps need no special handling here.
   function automatic pace_result_type pace_sample(input logic [31:0] now);
      logic [31:0] since;
      logic [31:0] diff;
      logic [31:0] excess;
      logic [31:0] elapsed;
      logic [63:0] quotient;
      pace_result_type result;
      since = now - pace_last_frame;
      diff = since * {22'd0, pace_fps} + pace_error;
      result.frame_due = 1'b0;
      result.rate_updated = 1'b0;
      if (diff >= fpt_pkg::ONE_SECOND) begin
         excess = diff - fpt_pkg::ONE_SECOND;
         pace_error = (excess < fpt_pkg::ONE_SECOND) ? excess : fpt_pkg::ONE_SECOND;
         pace_last_frame = now;
         result.frame_due = 1'b1;
         // The frame count sticks at its ceiling instead of wrapping.
         if (pace_count != fpt_pkg::COUNT_MAX) begin
            pace_count = pace_count + 16'd1;
         end
         elapsed = now - pace_window;
         if (elapsed >= fpt_pkg::ONE_SECOND) begin
            quotient = ({48'd0, pace_count} * 64'd256000) / {32'd0, elapsed};
            pace_rate = (quotient > {40'd0, fpt_pkg::RATE_MAX}) ?
                        fpt_pkg::RATE_MAX : quotient[23:0];
            pace_count = '0;
            pace_window = now;
            result.rate_updated = 1'b1;
         end
      end
      result.measured_rate = pace_rate;
      return result;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < REPORT_LIMIT) begin
         $display("tb: response %0d, %s: got %0h, expected %0h",
                  samples_answered, what, got, want);
      end
      mismatches++;
   endtask

   // Request side. A beat is predicted at the edge where it is accepted, so
   // the expectation always exists before its response can show up.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(pace_sample(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_tdata <= pending_samples.pop_front();
               req_tvalid <= 1'b1;
               if (idle_on && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(1, 9);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: compare each beat with the oldest prediction, then
   // decide whether to stall the next cycle.
   always @(posedge clock) begin
      pace_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            samples_answered++;
            if (expected_results.size() == 0) begin
               report_mismatch("beat with no sample outstanding", rsp_tdata, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.frame_due) begin
                  report_mismatch("frame_due", rsp_tdata[0], want.frame_due);
               end
               if (rsp_tuser !== want.rate_updated) begin
                  report_mismatch("rate_updated", rsp_tuser, want.rate_updated);
               end
               if (rsp_tdata[24:1] !== want.measured_rate) begin
                  report_mismatch("measured_rate", rsp_tdata[24:1], want.measured_rate);
               end
               if (rsp_tdata[31:25] !== 7'd0) begin
                  report_mismatch("padding", rsp_tdata[31:25], '0);
               end
               if (want.frame_due) frames_seen++;
               if (want.rate_updated) updates_seen++;
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap <= take_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            take_gap <= $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One long receiver hold-off, timed here so the sender keeps offering
   // beats and the unit has to back-pressure its request stream.
   always begin
      @(long_hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic queue_sample(input logic [31:0] t);
      pending_samples.push_back(t);
      samples_issued++;
      sample_ms = t;
   endtask

   task automatic wait_drained();
      while (samples_answered < samples_issued) @(posedge clock);
   endtask

   // The register is only written once every sample has been answered.
   task automatic set_target_fps(input logic [9:0] fps);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= fps;
      @(posedge clock);
      csr_we <= 1'b0;
      pace_fps = fps;
      rate_settings++;
   endtask

   // A run of samples moving forward by random steps, with occasional jumps
   // anywhere in the 32-bit range (backward ones included).
   task automatic queue_walk(input int count, input int max_step, input int noise_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1, 100) <= noise_pct) begin
            queue_sample($urandom);
         end else begin
            queue_sample(sample_ms + $urandom_range(0, max_step));
         end
      end
   endtask

   initial begin
      int          random_samples;
      int          phase_no;
      int          run_len;
      int          max_step;
      logic [9:0]  fps;

      random_samples = 0;
      phase_no = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed samples at the reset rate of 30: no frame at 990, a frame
      // just over 1000, then time wrapping and bit patterns of the field.
      idle_on = 1'b1;
      queue_sample(32'd0);
      queue_sample(32'd33);
      queue_sample(32'd34);
      queue_sample(32'hFFFF_FFFF);
      queue_sample(32'h8000_0000);
      queue_sample(32'h5555_5555);
      queue_sample(32'hAAAA_AAAA);
      queue_sample(32'h0000_0000);

      // Top legal rate: large steps drive the carried error to its cap.
      set_target_fps(10'd1000);
      queue_sample(32'd5000);
      queue_sample(32'd5003);
      queue_sample(32'd5004);
      queue_sample(32'd6010);

      // Zero target rate: pacing runs on the carried error alone, which
      // releases one frame at the same time stamp and then nothing more.
      set_target_fps(10'd0);
      queue_sample(32'd6010);
      queue_sample(32'd6011);
      queue_sample(32'd9000);

      // All register bits set, with wrapping time differences.
      set_target_fps(10'h3FF);
      queue_sample(32'd9001);
      queue_sample(32'd9002);
      queue_sample(32'hFFFF_FF00);
      queue_sample(32'h0000_0100);

      // Slowest rate: one frame per full second.
      set_target_fps(10'd1);
      queue_sample(32'h0000_0200);
      queue_sample(32'h0000_05E8);
      queue_sample(32'h0000_09D0);

      // Random phases, each under a new target rate. Mostly monotonic time
      // with step sizes chosen so measurement windows close regularly.
      while (random_samples < RANDOM_SAMPLES) begin
         case ($urandom_range(0, 5))
            0: fps = 10'd1000;
            1: fps = 10'd1;
            2: fps = $urandom_range(0, 1023);
            default: fps = $urandom_range(10, 240);
         endcase
         set_target_fps(fps);
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: max_step = 1;
            1: max_step = 4;
            2: max_step = 40;
            default: max_step = 200;
         endcase
         run_len = $urandom_range(40, 110);
         queue_walk(run_len, max_step, 8);
         if (phase_no == 1) begin
            -> long_hold_start;
         end
         random_samples += run_len;
         phase_no++;
      end

      // Last part, without idling on either stream: back-to-back samples
      // at a mid-range rate.
      set_target_fps(10'd60);
      idle_on = 1'b0;
      queue_walk(TAIL_SAMPLES, 40, 0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("samples left unanswered", expected_results.size(), '0);
      end

      $display("tb: %0d time samples under %0d target rate settings", samples_answered,
               rate_settings + 1);
      $display("tb: %0d frames released, %0d rate updates, with random stalls on both sides",
               frames_seen, updates_seen);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/fpt_pkg.sv
rtl/core/fpt_datapath.sv
rtl/core/fpt_ctrl.sv
rtl/core/frame_pacing_timer_unit.sv
tb/tb.sv
